[sv/f12chs_pkg.sv]
// shared constants, types and helpers for the fat12 cluster to chs engine
package f12chs_pkg;

	localparam int FAT_BYTES = 8192;
	localparam int FAT_AW    = $clog2(FAT_BYTES);

	localparam int CLUS_W    = 12;
	localparam int BADDR_W   = 13;
	localparam int POS_W     = 14;
	localparam int ADDR_W    = 20;
	localparam int DIV_W     = 9;
	localparam int CNT_W     = 5;
	localparam int DIV_STEPS = ADDR_W;
	localparam int CFG_W     = 16;

	localparam logic [ADDR_W:0] ADDR_MAX = 21'h0F_FFFF;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] CFG_DATA_START = 2'd0;
	localparam logic [1:0] CFG_SPC        = 2'd1;
	localparam logic [1:0] CFG_SPT        = 2'd2;
	localparam logic [1:0] CFG_HEADS      = 2'd3;

	localparam logic [15:0] RST_DATA_START = 16'd33;
	localparam logic [7:0]  RST_SPC        = 8'd1;
	localparam logic [5:0]  RST_SPT        = 6'd18;
	localparam logic [8:0]  RST_HEADS      = 9'd2;
	localparam logic [8:0]  HEADS_MAX      = 9'd256;

	localparam logic [CLUS_W-1:0] FAT_EOC  = 12'hFFF;
	localparam logic [CLUS_W-1:0] FAT_FREE = 12'h000;
	localparam logic [CLUS_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

	typedef struct packed {
		logic clr;
		logic en;
	} div_ctl_t;

	// odd clusters take the upper nibble of the low byte and all of the high byte
	function automatic logic [CLUS_W-1:0] fat_entry(input logic [7:0] lo,
		input logic [7:0] hi, input logic odd);
		logic [CLUS_W-1:0] r;
		if (odd) begin
			r = {hi, lo[7:4]};
		end else begin
			r = {hi[3:0], lo};
		end
		return r;
	endfunction

endpackage

[sv/f12chs_ram.sv]
// generic single-port ram with registered read
module f12chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[sv/f12chs_div.sv]
// bit-serial restoring divider step, dividend bits arrive msb first
module f12chs_div
	import f12chs_pkg::*;
(
	input  logic             clk,
	input  div_ctl_t         ctl,
	input  logic             bit_in,
	input  logic [DIV_W-1:0] divisor,
	output logic             q_bit,
	output logic [DIV_W-1:0] rem
);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;

	assign trial = {rem_q, bit_in};
	assign q_bit = (trial >= {1'b0, divisor});
	assign diff  = trial - {1'b0, divisor};
	assign rem   = rem_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			rem_q <= '0;
		end else if (ctl.en) begin
			// remainder stays below a nonzero divisor, so it fits
			rem_q <= q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

endmodule

[sv/fat12_cluster_to_chs_engine.sv]
// top level: fat12 table store, cluster address arithmetic and chs split
//
// Command channel: present opcode, byte_address, byte_value and cluster with
// start high; the transaction is taken at a rising edge where busy is low.
// Opcode 0 writes one byte of the table; opcode 1 looks up a cluster.
// Every transaction gives one result, shown for exactly one cycle with done
// high; the receiver cannot stall, so results must be taken at once.
// A write, or a lookup of a cluster below two, goes from idle straight to
// the output state, which registers done. A lookup reads both table bytes,
// forms the sector address and then runs two chained bit-serial dividers
// (by sectors per track, then by heads) for 20 steps, one address bit a cycle,
// before the output state; the next transaction may start on the cycle done
// is shown, and none is taken before the last one has given its result.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while no transaction is outstanding. cfg_ready is low while busy.
// Reset: arst_n clears the control state and loads the register defaults;
// the table store is not cleared and must be written before it is read.
module fat12_cluster_to_chs_engine
	import f12chs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [BADDR_W-1:0] byte_address,
	input  logic [7:0]         byte_value,
	input  logic [CLUS_W-1:0]  cluster,
	output logic               done,
	output logic [CLUS_W-1:0]  next_cluster,
	output logic               chain_end,
	output logic               bad_cluster,
	output logic [ADDR_W-1:0]  sector_address,
	output logic [ADDR_W-1:0]  cylinder,
	output logic [7:0]         head,
	output logic [5:0]         sector,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [15:0]       ds_q;
	logic [7:0]        spc_q;
	logic [5:0]        spt_q;
	logic [8:0]        hc_q;

	logic              op_q;
	logic [CLUS_W-1:0] clus_q;
	logic              lo_oob_q;
	logic              hi_oob_q;
	logic [7:0]        lo_q;
	logic [7:0]        hi_q;
	logic [ADDR_W-1:0] prod_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] sh_q;
	logic [ADDR_W-1:0] q2_q;

	logic [CLUS_W-1:0] next_q;
	logic              end_q;
	logic              bad_q;
	logic [ADDR_W-1:0] saddr_q;
	logic [ADDR_W-1:0] cyl_q;
	logic [7:0]        head_q;
	logic [5:0]        sect_q;

	logic              accept;
	logic              wr_in_range;
	logic [POS_W-1:0]  pos;
	logic [POS_W-1:0]  pos1;
	logic [ADDR_W:0]   sum;
	logic [ADDR_W-1:0] addr_sat;
	logic [8:0]        heads;
	logic              geom_ok;
	logic [CLUS_W-1:0] entry;

	logic              ram_we;
	logic [FAT_AW-1:0] ram_addr;
	logic [7:0]        ram_rdata;

	div_ctl_t          div_ctl;
	logic              q1_bit;
	logic              q2_bit;
	logic [DIV_W-1:0]  rem1;
	logic [DIV_W-1:0]  rem2;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	assign wr_in_range = (32'(byte_address) < FAT_BYTES);
	assign pos  = POS_W'(clus_q) + POS_W'(clus_q[CLUS_W-1:1]);
	assign pos1 = pos + POS_W'(1);

	assign sum      = (ADDR_W+1)'(ds_q) + (ADDR_W+1)'(prod_q);
	assign addr_sat = (sum > ADDR_MAX) ? ADDR_MAX[ADDR_W-1:0] : sum[ADDR_W-1:0];

	assign heads   = (hc_q > HEADS_MAX) ? HEADS_MAX : hc_q;
	assign geom_ok = (spt_q != 6'd0) && (heads != 9'd0);
	assign entry   = fat_entry(lo_q, hi_q, clus_q[0]);

	assign ram_we = accept && (opcode == OP_WRITE) && wr_in_range;

	always_comb begin
		priority if (!busy) begin
			ram_addr = FAT_AW'(byte_address);
		end else if (state_q == S_MUL) begin
			ram_addr = FAT_AW'(pos);
		end else begin
			ram_addr = FAT_AW'(pos1);
		end
	end

	f12chs_ram #(
		.WIDTH(8),
		.DEPTH(FAT_BYTES)
	) u_fat (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(byte_value),
		.rdata(ram_rdata)
	);

	assign div_ctl.clr = (state_q == S_ADD);
	assign div_ctl.en  = (state_q == S_DIV);

	// address / spt, its quotient bits stream straight into the divide by heads
	f12chs_div u_div_spt (
		.clk    (clk),
		.ctl    (div_ctl),
		.bit_in (sh_q[ADDR_W-1]),
		.divisor(DIV_W'(spt_q)),
		.q_bit  (q1_bit),
		.rem    (rem1)
	);

	f12chs_div u_div_heads (
		.clk    (clk),
		.ctl    (div_ctl),
		.bit_in (q1_bit),
		.divisor(heads),
		.q_bit  (q2_bit),
		.rem    (rem2)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_q  <= RST_DATA_START;
			spc_q <= RST_SPC;
			spt_q <= RST_SPT;
			hc_q  <= RST_HEADS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DATA_START: ds_q  <= cfg_data;
				CFG_SPC:        spc_q <= cfg_data[7:0];
				CFG_SPT:        spt_q <= cfg_data[5:0];
				CFG_HEADS:      hc_q  <= cfg_data[8:0];
				default:        ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_LOOKUP && cluster >= FIRST_DATA_CLUSTER) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			clus_q <= cluster;
		end
		if (state_q == S_MUL) begin
			prod_q   <= ADDR_W'(clus_q - FIRST_DATA_CLUSTER) * ADDR_W'(spc_q);
			lo_oob_q <= (32'(pos) >= FAT_BYTES);
			hi_oob_q <= (32'(pos1) >= FAT_BYTES);
		end
		if (state_q == S_ADD) begin
			lo_q   <= lo_oob_q ? 8'd0 : ram_rdata;
			addr_q <= addr_sat;
			sh_q   <= addr_sat;
		end
		if (state_q == S_DIV) begin
			if (cnt_q == '0) begin
				hi_q <= hi_oob_q ? 8'd0 : ram_rdata;
			end
			sh_q <= {sh_q[ADDR_W-2:0], 1'b0};
			q2_q <= {q2_q[ADDR_W-2:0], q2_bit};
		end
		if (state_q == S_OUT) begin
			next_q  <= '0;
			end_q   <= 1'b0;
			bad_q   <= 1'b0;
			saddr_q <= '0;
			cyl_q   <= '0;
			head_q  <= '0;
			sect_q  <= '0;
			if (op_q == OP_LOOKUP) begin
				if (clus_q < FIRST_DATA_CLUSTER) begin
					bad_q <= 1'b1;
				end else begin
					next_q  <= entry;
					end_q   <= (entry == FAT_EOC) || (entry == FAT_FREE);
					saddr_q <= addr_q;
					if (geom_ok) begin
						cyl_q  <= q2_q;
						head_q <= rem2[7:0];
						sect_q <= rem1[5:0] + 6'd1;
					end
				end
			end
		end
	end

	assign done           = done_q;
	assign next_cluster   = next_q;
	assign chain_end      = end_q;
	assign bad_cluster    = bad_q;
	assign sector_address = saddr_q;
	assign cylinder       = cyl_q;
	assign head           = head_q;
	assign sector         = sect_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_WRITE) |=> (state_q == S_OUT))
		else $error("table write did not go straight to the result");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)))
		else $error("divide step count out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && bad_cluster) |-> (sector_address == '0 && next_cluster == '0
			&& !chain_end))
		else $error("bad cluster result carries nonzero fields");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> (done_q && !busy))
		else $error("result not shown after the output state");

endmodule
